// ===== sv/lcs_pkg.sv =====
`timescale 1ns / 1ps
package lcs_pkg;

  // Default operand width of coef and rhs; modulus is one bit narrower.
  localparam int DATA_WIDTH_DEF = 32;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic qbit_vld;
    logic qbit;
  } div_stat_t;

endpackage

// ===== sv/lcs_if.sv =====
`timescale 1ns / 1ps
interface lcs_in_if #(parameter int DW = lcs_pkg::DATA_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] coef;
  logic signed [DW-1:0] rhs;
  logic        [DW-2:0] modulus;

  modport source (output valid, output coef, output rhs, output modulus, input ready);
  modport sink (input valid, input coef, input rhs, input modulus, output ready);
endinterface

interface lcs_out_if #(parameter int DW = lcs_pkg::DATA_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic                 solvable;
  logic        [DW-2:0] gcd_value;
  logic signed [DW-1:0] bezout_coef_x;
  logic signed [DW-1:0] bezout_coef_y;
  logic        [DW-2:0] least_solution;
  logic        [DW-2:0] solution_step;

  modport source (output valid, output solvable, output gcd_value, output bezout_coef_x,
                  output bezout_coef_y, output least_solution, output solution_step,
                  input ready);
  modport sink (input valid, input solvable, input gcd_value, input bezout_coef_x,
                input bezout_coef_y, input least_solution, input solution_step,
                output ready);
endinterface

// ===== sv/lcs_div.sv =====
`timescale 1ns / 1ps
module lcs_div #(
  parameter int DW = lcs_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [2*DW:0]                         dividend,
  input  logic [DW-1:0]                         divisor,
  input  logic [$clog2(2*DW+2)-1:0]             nbits,
  output lcs_pkg::div_stat_t                    stat,
  output logic [2*DW:0]                         quotient,
  output logic [DW-1:0]                         remainder
);
  import lcs_pkg::*;

  localparam int NW   = 2 * DW + 1;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   dvd_r, dvd_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   dvs_r, dvs_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, dvd_r[NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = busy_r && (cnt_r == CNTW'(1));
  assign stat.qbit_vld = busy_r;
  assign stat.qbit     = ge;
  assign quotient      = dvd_r;
  assign remainder     = rem_r;

endmodule

// ===== sv/linear_congruence_solver_top.sv =====
`timescale 1ns / 1ps
// Solves coef*x = rhs (mod modulus) one request at a time. The extended Euclidean
// algorithm runs on one shared bit-serial divider; the quotient bits are folded into
// the Bezout coefficient updates as they appear. The Euclid loop runs about 46 steps
// worst case on 32-bit operands; after the last Euclid check the finishing part runs
// rhs/gcd, modulus/gcd, one product, then a (2*DATA_WIDTH+1)-bit reduction by the
// solution step. The divider gives one quotient bit per cycle while busy.
// in_ch.ready is high only when the block is empty; the result stays on out_ch
// until taken. When the gcd does not divide rhs, or modulus is zero, the solution
// fields read zero.
module linear_congruence_solver_top #(
  parameter int DATA_WIDTH = lcs_pkg::DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  lcs_in_if.sink   in_ch,
  lcs_out_if.source out_ch
);
  import lcs_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int CW   = W + 2;
  localparam int NW   = 2 * W + 1;
  localparam int CNTW = $clog2(NW + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_EUCHK = 11'b00000000010,
    S_EUDIV = 11'b00000000100,
    S_EUUPD = 11'b00000001000,
    S_BDIV  = 11'b00000010000,
    S_BCHK  = 11'b00000100000,
    S_NDIV  = 11'b00001000000,
    S_MUL   = 11'b00010000000,
    S_PDIV  = 11'b00100000000,
    S_PCHK  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [W:0]    s_r, s_nxt;
  logic [W-1:0]         t_r, t_nxt;
  logic signed [CW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic [CW-1:0]        accx_r, accx_nxt, accy_r, accy_nxt;
  logic                 swap_r, swap_nxt, nsel_r, nsel_nxt;
  logic signed [W-1:0]  b_r, b_nxt;
  logic [W-2:0]         n_r, n_nxt;
  logic [W-1:0]         g_r, g_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [W-1:0]         bq_r, bq_nxt;
  logic                 pneg_r, pneg_nxt;
  logic                 solv_r, solv_nxt;
  logic [W-2:0]         least_r, least_nxt, step_r, step_nxt;

  logic                 div_start;
  logic [NW-1:0]        div_dvd;
  logic [W-1:0]         div_dvs;
  logic [CNTW-1:0]      div_nbits;
  div_stat_t            div_st;
  logic [NW-1:0]        div_quo;
  logic [W-1:0]         div_rem;

  // Input request decode
  logic signed [W:0]    a_ext, n_ext, a_neg;
  logic [W-1:0]         a_mag;
  logic                 in_swap;

  // Euclid helpers
  logic signed [W:0]    s_abs;
  logic signed [CW-1:0] p_fin, q_fin;
  logic signed [W:0]    b_ext, b_neg;
  logic signed [CW-1:0] cx_neg;
  logic [W:0]           cx_mag;
  logic                 adj;

  lcs_div #(.DW(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .nbits     (div_nbits),
    .stat      (div_st),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign a_ext   = {in_ch.coef[W-1], in_ch.coef};
  assign n_ext   = {2'b00, in_ch.modulus};
  assign a_neg   = -a_ext;
  assign a_mag   = in_ch.coef[W-1] ? a_neg[W-1:0] : a_ext[W-1:0];
  assign in_swap = {1'b0, in_ch.modulus} > a_mag;

  assign s_abs   = s_r[W] ? -s_r : s_r;
  assign p_fin   = s_r[W] ? -sx_r : sx_r;
  assign q_fin   = s_r[W] ? -sy_r : sy_r;
  assign b_ext   = {b_r[W-1], b_r};
  assign b_neg   = -b_ext;
  assign cx_neg  = -cx_r;
  assign cx_mag  = cx_r[CW-1] ? cx_neg[W:0] : cx_r[W:0];
  assign adj     = div_rem != '0;

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    swap_nxt  = swap_r;
    nsel_nxt  = nsel_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    g_nxt     = g_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    bq_nxt    = bq_r;
    pneg_nxt  = pneg_r;
    solv_nxt  = solv_r;
    least_nxt = least_r;
    step_nxt  = step_r;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_nbits = CNTW'(W);

    // Fold each quotient bit into q*tx and q*ty, most significant first
    if (div_st.qbit_vld) begin
      accx_nxt = {accx_r[CW-2:0], 1'b0} + (div_st.qbit ? tx_r : '0);
      accy_nxt = {accy_r[CW-2:0], 1'b0} + (div_st.qbit ? ty_r : '0);
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          // Order operands: larger magnitude first, second one non-negative
          swap_nxt = in_swap;
          nsel_nxt = in_swap && in_ch.coef[W-1];
          s_nxt    = in_swap ? (in_ch.coef[W-1] ? -n_ext : n_ext) : a_ext;
          t_nxt    = in_swap ? a_mag : {1'b0, in_ch.modulus};
          sx_nxt   = CW'(1);
          sy_nxt   = '0;
          tx_nxt   = '0;
          ty_nxt   = CW'(1);
          b_nxt    = in_ch.rhs;
          n_nxt    = in_ch.modulus;
          state_nxt = S_EUCHK;
        end
      end
      S_EUCHK: begin
        if (t_r == '0) begin
          // Euclid finished: fix the sign and undo the operand swap
          g_nxt  = s_abs[W-1:0];
          cx_nxt = swap_r ? (nsel_r ? -q_fin : q_fin) : p_fin;
          cy_nxt = swap_r ? (nsel_r ? -p_fin : p_fin) : q_fin;
          solv_nxt  = 1'b0;
          least_nxt = '0;
          step_nxt  = '0;
          if (n_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            div_start = 1'b1;
            div_dvd   = {(b_r[W-1] ? b_neg[W-1:0] : b_r), {(NW-W){1'b0}}};
            div_dvs   = s_abs[W-1:0];
            state_nxt = S_BDIV;
          end
        end else begin
          div_start = 1'b1;
          div_dvd   = {s_abs[W-1:0], {(NW-W){1'b0}}};
          div_dvs   = t_r;
          accx_nxt  = '0;
          accy_nxt  = '0;
          state_nxt = S_EUDIV;
        end
      end
      S_EUDIV: begin
        if (div_st.done) begin
          state_nxt = S_EUUPD;
        end
      end
      S_EUUPD: begin
        // Floor division step; only the first step can see a negative s
        s_nxt  = {1'b0, t_r};
        sx_nxt = tx_r;
        sy_nxt = ty_r;
        if (s_r[W]) begin
          t_nxt  = adj ? (t_r - div_rem) : '0;
          tx_nxt = sx_r + accx_r + (adj ? tx_r : '0);
          ty_nxt = sy_r + accy_r + (adj ? ty_r : '0);
        end else begin
          t_nxt  = div_rem;
          tx_nxt = sx_r - accx_r;
          ty_nxt = sy_r - accy_r;
        end
        state_nxt = S_EUCHK;
      end
      S_BDIV: begin
        if (div_st.done) begin
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (adj) begin
          state_nxt = S_OUT;
        end else begin
          bq_nxt    = div_quo[W-1:0];
          pneg_nxt  = cx_r[CW-1] ^ b_r[W-1];
          div_start = 1'b1;
          div_dvd   = {1'b0, n_r, {(NW-W){1'b0}}};
          div_dvs   = g_r;
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: begin
        if (div_st.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Solution step is modulus/gcd; reduce |x*(rhs/gcd)| by it next
        step_nxt  = div_quo[W-2:0];
        state_nxt = S_PDIV;
        div_start = 1'b1;
        div_dvd   = {{W{1'b0}}, cx_mag} * {{(W+1){1'b0}}, bq_r};
        div_dvs   = {1'b0, div_quo[W-2:0]};
        div_nbits = CNTW'(NW);
      end
      S_PDIV: begin
        if (div_st.done) begin
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        solv_nxt  = 1'b1;
        least_nxt = (pneg_r && adj) ? (step_r - div_rem[W-2:0]) : div_rem[W-2:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    s_r     <= s_nxt;
    t_r     <= t_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    accx_r  <= accx_nxt;
    accy_r  <= accy_nxt;
    swap_r  <= swap_nxt;
    nsel_r  <= nsel_nxt;
    b_r     <= b_nxt;
    n_r     <= n_nxt;
    g_r     <= g_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    bq_r    <= bq_nxt;
    pneg_r  <= pneg_nxt;
    solv_r  <= solv_nxt;
    least_r <= least_nxt;
    step_r  <= step_nxt;
  end

  assign in_ch.ready           = state_r == S_IDLE;
  assign out_ch.valid          = state_r == S_OUT;
  assign out_ch.solvable       = solv_r;
  assign out_ch.gcd_value      = g_r[W-2:0];
  assign out_ch.bezout_coef_x  = cx_r[W-1:0];
  assign out_ch.bezout_coef_y  = cy_r[W-1:0];
  assign out_ch.least_solution = least_r;
  assign out_ch.solution_step  = step_r;

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("input ready while a result waits");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");
  a_accept_euclid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_EUCHK)
    else $error("accepted request did not enter Euclid");
  a_least_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.solvable) |-> out_ch.least_solution < out_ch.solution_step)
    else $error("least solution not below step");

endmodule
